@@ hdl/ikc_pkg.sv @@
// Shared types, fixed-point constants and the CORDIC arctangent table for the
// two-link inverse kinematics core. No dependencies.
`default_nettype none

package ikc_pkg;

  // Width of Q30 angle accumulators and of the CORDIC vector registers.
  localparam int AW = 36;
  localparam int CW = 34;

  // Largest CORDIC iteration count the arctangent table supports.
  localparam int STEP_MAX = 24;

  // Angles in Q30 radians.
  localparam logic signed [AW-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [AW-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic [30:0]          ONE_Q30     = 31'h4000_0000;
  localparam logic [31:0]          PI_DEN      = 32'd3373259426;

  // Reciprocal of pi in Q30, scaled by 2^62, for the stepper conversion.
  localparam logic [30:0] STEP_RECIP = 31'((64'd1 << 62) / {32'd0, PI_DEN});

  // Angles in Q14 radians.
  localparam logic signed [20:0] PI_Q14     = 21'sd51472;
  localparam logic signed [20:0] TWO_PI_Q14 = 21'sd102944;
  localparam logic signed [20:0] LIMIT_Q14  = 21'sd34315;

  // Stepper gear factors (steps per pi radians, scaled).
  localparam logic signed [15:0] K_SHOULDER = 16'sd11520;
  localparam logic signed [15:0] K_ELBOW    = 16'sd12352;
  localparam logic signed [15:0] K_COUPLE   = 16'sd8864;

  // Square-root starting bit (2^60) and the value one squared in Q60.
  localparam logic [61:0] SQ_TOP = 62'h1000000000000000;

  // Configuration register indexes and reset values.
  localparam logic [1:0]  CFG_UPPER   = 2'd0;
  localparam logic [1:0]  CFG_LOWER   = 2'd1;
  localparam logic [13:0] UPPER_RESET = 14'd5120;
  localparam logic [13:0] LOWER_RESET = 14'd4352;

  // One classified target handed from the front end to the solver.
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [31:0]        r2;
    logic               ok;
    logic               stretch;
  } ikc_item_t;

  // atan(2^-i) in Q30 radians.
  function automatic logic [29:0] atan_entry(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd843314856;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043836;
      5'd3:  v = 30'd133525158;
      5'd4:  v = 30'd67021686;
      5'd5:  v = 30'd33543515;
      5'd6:  v = 30'd16775850;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194282;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048575;
      5'd11: v = 30'd524287;
      5'd12: v = 30'd262143;
      5'd13: v = 30'd131071;
      5'd14: v = 30'd65535;
      5'd15: v = 30'd32767;
      5'd16: v = 30'd16383;
      5'd17: v = 30'd8191;
      5'd18: v = 30'd4095;
      5'd19: v = 30'd2047;
      5'd20: v = 30'd1023;
      5'd21: v = 30'd511;
      5'd22: v = 30'd255;
      5'd23: v = 30'd127;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ hdl/ikc_front.sv @@
// Front end: accepts target items, squares coordinates and link span, classifies
// reachability and queues classified items for the solver. Uses ikc_pkg.
`default_nettype none

module ikc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] target_x,
  input  logic signed [15:0] target_y,
  input  logic [13:0]        upper_len,
  input  logic [13:0]        lower_len,
  output logic               q_valid,
  output ikc_pkg::ikc_item_t q_item,
  input  logic               q_pop
);

  logic               accept;
  logic               s1_v_r, s1_v_nxt;
  logic signed [15:0] s1_x_r, s1_y_r;
  logic [31:0]        s1_xx_r, s1_yy_r;
  logic [29:0]        s1_ss_r;
  logic signed [31:0] xx_full, yy_full;
  logic [14:0]        span;
  logic [29:0]        ss_full;
  logic [31:0]        r2;
  ikc_pkg::ikc_item_t new_item;
  ikc_pkg::ikc_item_t q_mem [2];
  logic               q_wp_r, q_rp_r;
  logic [1:0]         q_cnt_r, q_cnt_nxt;
  logic               q_push;

  // Squares of the target and of the full link span.
  assign xx_full = target_x * target_x;
  assign yy_full = target_y * target_y;
  assign span    = {1'b0, upper_len} + {1'b0, lower_len};
  assign ss_full = span * span;

  // Stage one holds the products; it advances when the queue has room.
  assign q_push   = s1_v_r && (q_cnt_r != 2'd2);
  assign full     = s1_v_r && (q_cnt_r == 2'd2);
  assign accept   = push && !full;
  assign s1_v_nxt = accept || (s1_v_r && !q_push);

  // Reachability: nonzero radius no larger than the span.
  assign r2               = s1_xx_r + s1_yy_r;
  assign new_item.x       = s1_x_r;
  assign new_item.y       = s1_y_r;
  assign new_item.r2      = r2;
  assign new_item.ok      = (r2 != 32'd0) && (r2 <= {2'b00, s1_ss_r});
  assign new_item.stretch = (r2 == {2'b00, s1_ss_r});

  assign q_valid   = (q_cnt_r != 2'd0);
  assign q_item    = q_mem[q_rp_r];
  assign q_cnt_nxt = q_cnt_r + {1'b0, q_push} - {1'b0, q_pop};

  // Stage one registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
    if (accept) begin
      s1_x_r  <= target_x;
      s1_y_r  <= target_y;
      s1_xx_r <= xx_full;
      s1_yy_r <= yy_full;
      s1_ss_r <= ss_full;
    end
  end

  // Two-entry queue between front end and solver.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wp_r  <= 1'b0;
      q_rp_r  <= 1'b0;
      q_cnt_r <= 2'd0;
    end else begin
      q_cnt_r <= q_cnt_nxt;
      if (q_push) begin
        q_wp_r <= !q_wp_r;
      end
      if (q_pop) begin
        q_rp_r <= !q_rp_r;
      end
    end
    if (q_push) begin
      q_mem[q_wp_r] <= new_item;
    end
  end

endmodule

`default_nettype wire

@@ hdl/ikc_back.sv @@
// Solver: sequences one shared CORDIC, a bit-serial square root, a restoring
// divider and a reciprocal multiply to produce joint angles and stepper
// positions. Uses ikc_pkg.
`default_nettype none

module ikc_back #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  ikc_pkg::ikc_item_t q_item,
  output logic               q_pop,
  input  logic [13:0]        upper_len,
  input  logic [13:0]        lower_len,
  input  logic               out_pop,
  output logic               out_valid,
  output logic               out_reachable,
  output logic signed [16:0] out_shoulder_angle,
  output logic signed [16:0] out_elbow_angle,
  output logic signed [13:0] out_shoulder_steps,
  output logic signed [14:0] out_elbow_steps
);

  localparam int AW = ikc_pkg::AW;
  localparam int CW = ikc_pkg::CW;

  typedef enum logic [4:0] {
    B_IDLE, B_BASE, B_RQ, B_PREP, B_NUM, B_AC0, B_ACDIV, B_ACSQ, B_ACSQL,
    B_ACSQRT, B_ACCORD, B_ACDONE, B_FIN, B_MUL, B_SUM, B_DSH, B_DCHK, B_DEL
  } state_t;

  state_t state_r;

  // CORDIC registers and one rotation step.
  logic signed [CW-1:0] cx_r, cy_r, cx_n, cy_n, sx, sy;
  logic signed [AW-1:0] cz_r, cz_n, at;
  logic [4:0]           ci_r;
  logic                 cord_last;
  logic signed [CW-1:0] cs_x, cs_y, cx0, cy0;
  logic signed [AW-1:0] cz0;

  // Square root registers and one digit step.
  logic [61:0] sv_r, sres_r, sbit_r, sv_n, sres_n;
  logic [62:0] rb;
  logic        sge, sqrt_last;

  // Divider registers and one quotient bit step.
  logic [39:0] drem_r, drem_n;
  logic [38:0] dden_r;
  logic [29:0] dq_r, dq_n;
  logic [4:0]  dcnt_r, dlast_r;
  logic [40:0] rem2;
  logic        dge, div_last;

  // Stepper conversion: reciprocal products, estimates and checks.
  logic [60:0] shp_r, elp_r;
  logic [14:0] shq_est, elq_est, shq_r, elq_r, shq_fix, elq_fix;
  logic [47:0] sht_r, elt_r;
  logic        sh_up, el_up;

  // Solver working registers.
  logic [31:0]          r2_r;
  logic                 stretch_r;
  logic signed [AW-1:0] base_r, a1q_r, a2q_r, acres_r;
  logic [23:0]          rq_r;
  logic [27:0]          l1sq_r, l2sq_r, l1l2_r;
  logic [37:0]          l1rq_r;
  logic signed [40:0]   an_r;
  logic [38:0]          ad_r, de_r;
  logic signed [32:0]   ne_r;
  logic [40:0]          amag;
  logic [30:0]          acm_r;
  logic [61:0]          acsq_r;
  logic                 aneg_r, which_r;
  logic signed [16:0]   a1_r, a2_r;
  logic signed [31:0]   psh_r, pe2_r, pe1_r;
  logic signed [32:0]   elsum_r;
  logic [31:0]          psh_mag;
  logic [32:0]          el_mag;
  logic signed [32:0]   nsum;

  // Architectural state and result register.
  logic               out_v_r, reach_r;
  logic signed [16:0] prev_sa_r, prev_ea_r;
  logic signed [13:0] prev_ss_r;
  logic signed [14:0] prev_es_r;

  // Round Q30 to Q14, wrap within pi of the previous angle, clamp to 2pi/3.
  function automatic logic signed [16:0] wrap_clamp(input logic signed [AW-1:0] q30,
                                                    input logic signed [16:0] prev);
    logic signed [AW-1:0] rnd;
    logic signed [20:0]   t;
    logic signed [20:0]   d;
    rnd = q30 + 36'sd32768;
    t   = 21'(rnd >>> 16);
    d   = t - 21'(prev);
    if (d > ikc_pkg::PI_Q14) begin
      t = t - ikc_pkg::TWO_PI_Q14;
    end else if (d < -ikc_pkg::PI_Q14) begin
      t = t + ikc_pkg::TWO_PI_Q14;
    end
    if (t > ikc_pkg::LIMIT_Q14) begin
      t = ikc_pkg::LIMIT_Q14;
    end
    if (t < -ikc_pkg::LIMIT_Q14) begin
      t = -ikc_pkg::LIMIT_Q14;
    end
    return t[16:0];
  endfunction

  // CORDIC vectoring step with floor shifts.
  assign sx        = cx_r >>> ci_r;
  assign sy        = cy_r >>> ci_r;
  assign at        = $signed({6'd0, ikc_pkg::atan_entry(ci_r)});
  assign cx_n      = (cy_r > 0) ? cx_r + sy : cx_r - sy;
  assign cy_n      = (cy_r > 0) ? cy_r - sx : cy_r + sx;
  assign cz_n      = (cy_r > 0) ? cz_r + at : cz_r - at;
  assign cord_last = (ci_r == 5'(CORDIC_STEPS - 1));

  // CORDIC operand source: the target point, or (sine, cosine) of an acos.
  always_comb begin
    if (state_r == B_ACSQRT) begin
      cs_y = $signed({2'b00, sres_n[31:0]});
      cs_x = aneg_r ? -$signed({3'b000, acm_r}) : $signed({3'b000, acm_r});
    end else begin
      cs_y = $signed({{4{q_item.y[15]}}, q_item.y, 14'd0});
      cs_x = $signed({{4{q_item.x[15]}}, q_item.x, 14'd0});
    end
  end

  // Left half-plane points are turned by pi before iterating.
  assign cx0 = (cs_x < 0) ? -cs_x : cs_x;
  assign cy0 = (cs_x < 0) ? -cs_y : cs_y;
  assign cz0 = (cs_x < 0) ? ((cs_y >= 0) ? ikc_pkg::PI_Q30 : -ikc_pkg::PI_Q30)
                          : '0;

  // Square root digit step.
  assign rb        = {1'b0, sres_r} + {1'b0, sbit_r};
  assign sge       = ({1'b0, sv_r} >= rb);
  assign sv_n      = sge ? (sv_r - rb[61:0]) : sv_r;
  assign sres_n    = sge ? ((sres_r >> 1) + sbit_r) : (sres_r >> 1);
  assign sqrt_last = (sbit_r == 62'd1);

  // Restoring division step.
  assign rem2     = {drem_r, 1'b0};
  assign dge      = (rem2 >= {2'b00, dden_r});
  assign drem_n   = dge ? 40'(rem2 - {2'b00, dden_r}) : rem2[39:0];
  assign dq_n     = {dq_r[28:0], dge};
  assign div_last = (dcnt_r == dlast_r);

  // Operand magnitudes.
  assign amag    = an_r[40] ? 41'(-an_r) : 41'(an_r);
  assign psh_mag = psh_r[31] ? 32'(-psh_r) : 32'(psh_r);
  assign el_mag  = elsum_r[32] ? 33'(-elsum_r) : 33'(elsum_r);
  assign nsum    = $signed({1'b0, r2_r}) + $signed({5'd0, l1sq_r})
                 - $signed({5'd0, l2sq_r});

  // The reciprocal estimate is at most one below the true quotient; the
  // registered check product decides whether to add that one.
  assign shq_est = shp_r[60:46];
  assign elq_est = elp_r[60:46];
  assign sh_up   = (sht_r <= {2'b00, psh_mag[29:0], 16'd0});
  assign el_up   = (elt_r <= {2'b00, el_mag[29:0], 16'd0});
  assign shq_fix = shq_r + {14'd0, sh_up};
  assign elq_fix = elq_r + {14'd0, el_up};

  assign q_pop = (state_r == B_IDLE) && q_valid && !out_v_r;

  // Result fields mirror the held state while a result waits.
  assign out_valid          = out_v_r;
  assign out_reachable      = reach_r;
  assign out_shoulder_angle = prev_sa_r;
  assign out_elbow_angle    = prev_ea_r;
  assign out_shoulder_steps = prev_ss_r;
  assign out_elbow_steps    = prev_es_r;

  // Solver sequence.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_IDLE;
      out_v_r   <= 1'b0;
      reach_r   <= 1'b0;
      prev_sa_r <= '0;
      prev_ea_r <= '0;
      prev_ss_r <= '0;
      prev_es_r <= '0;
    end else begin
      if (out_pop) begin
        out_v_r <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          if (q_pop) begin
            if (!q_item.ok) begin
              out_v_r <= 1'b1;
              reach_r <= 1'b0;
            end else begin
              r2_r      <= q_item.r2;
              stretch_r <= q_item.stretch;
              cx_r      <= cx0;
              cy_r      <= cy0;
              cz_r      <= cz0;
              ci_r      <= 5'd0;
              state_r   <= B_BASE;
            end
          end
        end
        B_BASE: begin
          cx_r <= cx_n;
          cy_r <= cy_n;
          cz_r <= cz_n;
          ci_r <= ci_r + 5'd1;
          if (cord_last) begin
            base_r <= ikc_pkg::HALF_PI_Q30 - cz_n;
            if (stretch_r) begin
              a1q_r   <= ikc_pkg::HALF_PI_Q30 - cz_n;
              a2q_r   <= '0;
              state_r <= B_FIN;
            end else begin
              sv_r    <= {14'd0, r2_r, 16'd0};
              sres_r  <= '0;
              sbit_r  <= ikc_pkg::SQ_TOP;
              state_r <= B_RQ;
            end
          end
        end
        B_RQ: begin
          sv_r   <= sv_n;
          sres_r <= sres_n;
          sbit_r <= sbit_r >> 2;
          if (sqrt_last) begin
            rq_r    <= sres_n[23:0];
            state_r <= B_PREP;
          end
        end
        B_PREP: begin
          l1sq_r  <= upper_len * upper_len;
          l2sq_r  <= lower_len * lower_len;
          l1l2_r  <= upper_len * lower_len;
          l1rq_r  <= upper_len * rq_r;
          state_r <= B_NUM;
        end
        B_NUM: begin
          an_r    <= {nsum, 8'd0};
          ad_r    <= {l1rq_r, 1'b0};
          ne_r    <= $signed({5'd0, l1sq_r}) + $signed({5'd0, l2sq_r})
                   - $signed({1'b0, r2_r});
          de_r    <= {10'd0, l1l2_r, 1'b0};
          which_r <= 1'b0;
          state_r <= B_AC0;
        end
        B_AC0: begin
          aneg_r <= an_r[40];
          if (ad_r == 39'd0) begin
            if (an_r > 0) begin
              acres_r <= '0;
            end else if (an_r < 0) begin
              acres_r <= ikc_pkg::PI_Q30;
            end else begin
              acres_r <= ikc_pkg::HALF_PI_Q30;
            end
            state_r <= B_ACDONE;
          end else if (amag >= {2'b00, ad_r}) begin
            acm_r   <= ikc_pkg::ONE_Q30;
            state_r <= B_ACSQ;
          end else begin
            drem_r  <= amag[39:0];
            dden_r  <= ad_r;
            dq_r    <= '0;
            dcnt_r  <= 5'd0;
            dlast_r <= 5'd29;
            state_r <= B_ACDIV;
          end
        end
        B_ACDIV: begin
          drem_r <= drem_n;
          dq_r   <= dq_n;
          dcnt_r <= dcnt_r + 5'd1;
          if (div_last) begin
            acm_r   <= {1'b0, dq_n};
            state_r <= B_ACSQ;
          end
        end
        B_ACSQ: begin
          acsq_r  <= acm_r * acm_r;
          state_r <= B_ACSQL;
        end
        B_ACSQL: begin
          sv_r    <= ikc_pkg::SQ_TOP - acsq_r;
          sres_r  <= '0;
          sbit_r  <= ikc_pkg::SQ_TOP;
          state_r <= B_ACSQRT;
        end
        B_ACSQRT: begin
          sv_r   <= sv_n;
          sres_r <= sres_n;
          sbit_r <= sbit_r >> 2;
          if (sqrt_last) begin
            cx_r    <= cx0;
            cy_r    <= cy0;
            cz_r    <= cz0;
            ci_r    <= 5'd0;
            state_r <= B_ACCORD;
          end
        end
        B_ACCORD: begin
          cx_r <= cx_n;
          cy_r <= cy_n;
          cz_r <= cz_n;
          ci_r <= ci_r + 5'd1;
          if (cord_last) begin
            acres_r <= cz_n;
            state_r <= B_ACDONE;
          end
        end
        B_ACDONE: begin
          if (!which_r) begin
            a1q_r   <= base_r - acres_r;
            an_r    <= {{8{ne_r[32]}}, ne_r};
            ad_r    <= de_r;
            which_r <= 1'b1;
            state_r <= B_AC0;
          end else begin
            a2q_r   <= ikc_pkg::PI_Q30 - acres_r;
            state_r <= B_FIN;
          end
        end
        B_FIN: begin
          a1_r    <= wrap_clamp(a1q_r, prev_sa_r);
          a2_r    <= wrap_clamp(a2q_r, prev_ea_r);
          state_r <= B_MUL;
        end
        B_MUL: begin
          psh_r   <= a1_r * ikc_pkg::K_SHOULDER;
          pe2_r   <= a2_r * ikc_pkg::K_ELBOW;
          pe1_r   <= a1_r * ikc_pkg::K_COUPLE;
          state_r <= B_SUM;
        end
        B_SUM: begin
          elsum_r <= -($signed({pe2_r[31], pe2_r}) + $signed({pe1_r[31], pe1_r}));
          state_r <= B_DSH;
        end
        // Both magnitudes stay below 2^30, so 30 bits feed the multipliers.
        B_DSH: begin
          shp_r   <= psh_mag[29:0] * ikc_pkg::STEP_RECIP;
          elp_r   <= el_mag[29:0] * ikc_pkg::STEP_RECIP;
          state_r <= B_DCHK;
        end
        B_DCHK: begin
          shq_r   <= shq_est;
          elq_r   <= elq_est;
          sht_r   <= ({1'b0, shq_est} + 16'd1) * ikc_pkg::PI_DEN;
          elt_r   <= ({1'b0, elq_est} + 16'd1) * ikc_pkg::PI_DEN;
          state_r <= B_DEL;
        end
        B_DEL: begin
          prev_sa_r <= a1_r;
          prev_ea_r <= a2_r;
          prev_ss_r <= psh_r[31] ? -$signed(shq_fix[13:0]) : $signed(shq_fix[13:0]);
          prev_es_r <= elsum_r[32] ? -$signed(elq_fix) : $signed(elq_fix);
          reach_r   <= 1'b1;
          out_v_r   <= 1'b1;
          state_r   <= B_IDLE;
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hdl/two_link_inverse_kinematics_core.sv @@
// Top level of the two-link inverse kinematics core: configuration registers,
// front end and solver. Depends on ikc_pkg, ikc_front and ikc_back.
//
// Usage: targets enter as a queue push (push high, full low) carrying
// in_target_x and in_target_y in 1/256 cm. Results leave as a queue: while
// empty is low the oldest result is on the out_ ports and pop takes it.
// One result per target. Link lengths are written on the cfg_ channel
// (cfg_ready is always high); index 0 is the upper link, 1 the lower link,
// other indexes are ignored. Write them only while the core is idle.
// An unreachable target's result passes the front end's stage one register,
// the two-entry queue and the solver's result register. A reachable target
// also uses the solver's shared CORDIC and, unless fully stretched, the
// bit-serial square root and the restoring divider, which run one after
// another. The solver works on one target at a time; a two-entry queue
// behind the front end keeps accepting targets while the solver is busy or a
// result waits to be popped. Reset clears the control state, angles and
// positions to zero and restores the default link lengths. A held result
// stalls the solver until it is popped.
`default_nettype none

module two_link_inverse_kinematics_core #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] in_target_x,
  input  logic signed [15:0] in_target_y,
  output logic               empty,
  input  logic               pop,
  output logic               out_reachable,
  output logic signed [16:0] out_shoulder_angle,
  output logic signed [16:0] out_elbow_angle,
  output logic signed [13:0] out_shoulder_steps,
  output logic signed [14:0] out_elbow_steps,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [13:0]        cfg_data
);

  logic [13:0]        upper_len_r, lower_len_r;
  logic               q_valid, q_pop, out_valid, out_pop;
  ikc_pkg::ikc_item_t q_item;

  assign cfg_ready = 1'b1;
  assign empty     = !out_valid;
  assign out_pop   = pop && out_valid;

  // Link length registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_len_r <= ikc_pkg::UPPER_RESET;
      lower_len_r <= ikc_pkg::LOWER_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == ikc_pkg::CFG_UPPER) begin
        upper_len_r <= cfg_data;
      end else if (cfg_index == ikc_pkg::CFG_LOWER) begin
        lower_len_r <= cfg_data;
      end
    end
  end

  ikc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .target_x  (in_target_x),
    .target_y  (in_target_y),
    .upper_len (upper_len_r),
    .lower_len (lower_len_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  ikc_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_item             (q_item),
    .q_pop              (q_pop),
    .upper_len          (upper_len_r),
    .lower_len          (lower_len_r),
    .out_pop            (out_pop),
    .out_valid          (out_valid),
    .out_reachable      (out_reachable),
    .out_shoulder_angle (out_shoulder_angle),
    .out_elbow_angle    (out_elbow_angle),
    .out_shoulder_steps (out_shoulder_steps),
    .out_elbow_steps    (out_elbow_steps)
  );

endmodule

`default_nettype wire

@@ hdl/ikc_checker.sv @@
// Port-level checks for the two-link inverse kinematics core, bound to the top
// level. Depends only on the top level's ports.
`default_nettype none

module ikc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               empty,
  input logic               pop,
  input logic signed [16:0] out_shoulder_angle,
  input logic signed [16:0] out_elbow_angle,
  input logic signed [13:0] out_shoulder_steps,
  input logic signed [14:0] out_elbow_steps
);

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result present after reset");

  // A waiting result holds until it is popped.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_shoulder_angle)
                          && $stable(out_elbow_steps)))
    else $error("waiting result changed");

  // Angles stay inside the joint limit.
  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_shoulder_angle <= 17'sd34315 && out_shoulder_angle >= -17'sd34315
                && out_elbow_angle <= 17'sd34315 && out_elbow_angle >= -17'sd34315))
    else $error("angle outside joint limit");

  // A non-negative shoulder angle never comes with negative shoulder steps.
  a_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_shoulder_angle[16]) |-> !out_shoulder_steps[13])
    else $error("shoulder steps sign mismatch");

endmodule

bind two_link_inverse_kinematics_core ikc_checker u_ikc_checker (.*);

`default_nettype wire

@@ tb/two_link_inverse_kinematics_core_tb.sv @@
// Self-checking testbench for the two-link inverse kinematics core: directed
// targets and link settings, then random targets checked against a predictor.
// Depends on ikc_pkg and two_link_inverse_kinematics_core.
`default_nettype none

module two_link_inverse_kinematics_core_tb;

  localparam int STEPS = 16;
  localparam int SETTLE = 400;
  localparam int WATCH_LIMIT = 20000;

  localparam longint PI30 = 64'd3373259426;
  localparam longint HPI30 = 64'd1686629713;
  localparam longint ONE30 = 64'd1073741824;
  localparam longint PI14 = 51472;
  localparam longint TWOPI14 = 102944;
  localparam longint LIM14 = 34315;

  typedef struct packed {
    logic               reachable;
    logic signed [16:0] shoulder_angle;
    logic signed [16:0] elbow_angle;
    logic signed [13:0] shoulder_steps;
    logic signed [14:0] elbow_steps;
  } pose_t;

  // Directed targets; a known pose is typed in only where it is obvious.
  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    bit                 known;
    pose_t              pose;
  } target_row_t;

  logic clk, rst_n;
  logic push, full, empty, pop;
  logic signed [15:0] in_target_x, in_target_y;
  logic out_reachable;
  logic signed [16:0] out_shoulder_angle, out_elbow_angle;
  logic signed [13:0] out_shoulder_steps;
  logic signed [14:0] out_elbow_steps;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [13:0] cfg_data;

  two_link_inverse_kinematics_core #(.CORDIC_STEPS(STEPS)) DUT (.*);

  // Predictor state: link lengths and the last accepted pose.
  longint upper_len, lower_len;
  longint last_sh, last_el, last_sh_st, last_el_st;
  pose_t expected_poses[$];
  int errors;
  int idle_cycles;
  bit calm;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint floor_shift(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint floor_sqrt(longint v);
    longint res, b;
    res = 0;
    b = longint'(1) << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint atan_q30(longint y, longint x);
    longint z, nx;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? PI30 : -PI30;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STEPS && i < ikc_pkg::STEP_MAX; i++) begin
      if (y > 0) begin
        nx = x + floor_shift(y, i);
        y = y - floor_shift(x, i);
        z = z + longint'(ikc_pkg::atan_entry(i[4:0]));
      end else begin
        nx = x - floor_shift(y, i);
        y = y + floor_shift(x, i);
        z = z - longint'(ikc_pkg::atan_entry(i[4:0]));
      end
      x = nx;
    end
    return z;
  endfunction

  // Arc cosine of n/d in Q30, with the ratio saturated to [-1, 1].
  function automatic longint acos_q30(longint n, longint d);
    longint mag, cm, q, rem, c, s;
    if (d == 0) begin
      if (n > 0) return 0;
      if (n < 0) return PI30;
      return HPI30;
    end
    mag = (n < 0) ? -n : n;
    if (mag >= d) begin
      cm = ONE30;
    end else begin
      q = 0;
      rem = mag;
      for (int i = 0; i < 30; i++) begin
        rem = rem << 1;
        q = q << 1;
        if (rem >= d) begin
          rem = rem - d;
          q = q | 1;
        end
      end
      cm = q;
    end
    c = (n < 0) ? -cm : cm;
    s = floor_sqrt((longint'(1) << 60) - cm * cm);
    return atan_q30(s, c);
  endfunction

  // Round to Q14, wrap to within pi of the previous angle, then clamp.
  function automatic longint joint_angle(longint q30, longint prev);
    longint t;
    t = (q30 + 32768) >>> 16;
    if (t - prev > PI14) t = t - TWOPI14;
    else if (t - prev < -PI14) t = t + TWOPI14;
    if (t > LIM14) t = LIM14;
    if (t < -LIM14) t = -LIM14;
    return t;
  endfunction

  function automatic longint motor_steps(longint num);
    longint mag, q;
    mag = (num < 0) ? -num : num;
    q = (mag * 65536) / PI30;
    return (num < 0) ? -q : q;
  endfunction

  function automatic pose_t solve_pose(logic signed [15:0] tx, logic signed [15:0] ty);
    longint x, y, r2, span, s2, base, a1q, a2q, rq, ns, ds, ne, de;
    pose_t p;
    x = tx;
    y = ty;
    r2 = x * x + y * y;
    span = upper_len + lower_len;
    s2 = span * span;
    p.reachable = (r2 != 0) && (r2 <= s2);
    if (p.reachable) begin
      base = HPI30 - atan_q30(y * 16384, x * 16384);
      if (r2 == s2) begin
        a1q = base;
        a2q = 0;
      end else begin
        rq = floor_sqrt(r2 << 16);
        ns = (r2 + upper_len * upper_len - lower_len * lower_len) * 256;
        ds = 2 * upper_len * rq;
        ne = upper_len * upper_len + lower_len * lower_len - r2;
        de = 2 * upper_len * lower_len;
        a1q = base - acos_q30(ns, ds);
        a2q = PI30 - acos_q30(ne, de);
      end
      last_sh = joint_angle(a1q, last_sh);
      last_el = joint_angle(a2q, last_el);
      last_sh_st = motor_steps(last_sh * 11520);
      last_el_st = motor_steps(-(last_el * 12352 + last_sh * 8864));
    end
    p.shoulder_angle = last_sh[16:0];
    p.elbow_angle = last_el[16:0];
    p.shoulder_steps = last_sh_st[13:0];
    p.elbow_steps = last_el_st[14:0];
    return p;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Field by field comparison of two poses.
  task automatic check_pose(string tag, pose_t got, pose_t want);
    if (got.reachable !== want.reachable)
      report_mismatch({tag, " reachable"}, got.reachable, want.reachable);
    if (got.shoulder_angle !== want.shoulder_angle)
      report_mismatch({tag, " shoulder_angle"}, got.shoulder_angle, want.shoulder_angle);
    if (got.elbow_angle !== want.elbow_angle)
      report_mismatch({tag, " elbow_angle"}, got.elbow_angle, want.elbow_angle);
    if (got.shoulder_steps !== want.shoulder_steps)
      report_mismatch({tag, " shoulder_steps"}, got.shoulder_steps, want.shoulder_steps);
    if (got.elbow_steps !== want.elbow_steps)
      report_mismatch({tag, " elbow_steps"}, got.elbow_steps, want.elbow_steps);
  endtask

  // Compare each popped result with the oldest expected pose.
  always @(posedge clk) begin
    pose_t e, g;
    if (rst_n && pop && !empty) begin
      if (expected_poses.size() == 0) begin
        report_mismatch("results beyond expected count", 1, 0);
      end else begin
        e = expected_poses.pop_front();
        g = '{out_reachable, out_shoulder_angle, out_elbow_angle,
              out_shoulder_steps, out_elbow_steps};
        check_pose("result", g, e);
      end
    end
  end

  // Random pop stalls in bursts, none in the calm tail of the run.
  initial begin
    int gap;
    pop = 0;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 7);
        pop <= 0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1;
    end
  end

  // Watchdog on cycles without any accepted item or result.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_target(logic signed [15:0] tx, logic signed [15:0] ty);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      push <= 0;
      repeat (gap) @(posedge clk);
    end
    push <= 1;
    in_target_x <= tx;
    in_target_y <= ty;
    @(posedge clk);
    while (full) @(posedge clk);
    expected_poses.push_back(solve_pose(tx, ty));
  endtask

  // Drain, then write one link length while the core is idle.
  task automatic write_link(logic [1:0] idx, logic [13:0] len);
    push <= 0;
    @(posedge clk);
    while (expected_poses.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= len;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    if (idx == ikc_pkg::CFG_UPPER) upper_len = len;
    else if (idx == ikc_pkg::CFG_LOWER) lower_len = len;
  endtask

  // Mostly reachable targets scaled to the current reach, some anywhere.
  task automatic random_targets(int n);
    longint reach, rx, ry;
    for (int i = 0; i < n; i++) begin
      reach = upper_len + lower_len;
      if (reach > 23000) reach = 23000;
      if ($urandom_range(0, 3) == 0 || reach < 2) begin
        rx = $signed(16'($urandom));
        ry = $signed(16'($urandom));
      end else begin
        rx = longint'($urandom_range(0, 2 * reach)) - reach;
        ry = longint'($urandom_range(0, 2 * reach)) - reach;
      end
      send_target(rx[15:0], ry[15:0]);
    end
  endtask

  target_row_t directed[$];
  pose_t zero_miss, pose_tmp;

  initial begin
    errors = 0;
    calm = 0;
    rst_n = 0;
    push = 0;
    in_target_x = 0;
    in_target_y = 0;
    cfg_valid = 0;
    cfg_index = ikc_pkg::CFG_UPPER;
    cfg_data = 0;
    upper_len = ikc_pkg::UPPER_RESET;
    lower_len = ikc_pkg::LOWER_RESET;
    last_sh = 0; last_el = 0; last_sh_st = 0; last_el_st = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: origin and far corners are unreachable with a zero pose.
    zero_miss = '{1'b0, 17'sd0, 17'sd0, 14'sd0, 15'sd0};
    directed.push_back('{16'sd0, 16'sd0, 1, zero_miss});
    directed.push_back('{-16'sd32768, -16'sd32768, 1, zero_miss});
    directed.push_back('{16'sd32767, 16'sd32767, 1, zero_miss});
    directed.push_back('{16'sd0, 16'sd9472, 0, zero_miss});
    directed.push_back('{16'sd9472, 16'sd0, 0, zero_miss});
    directed.push_back('{-16'sd9472, 16'sd0, 0, zero_miss});
    directed.push_back('{16'sd0, -16'sd9472, 0, zero_miss});
    directed.push_back('{16'sd1, 16'sd0, 0, zero_miss});
    directed.push_back('{-16'sd1, -16'sd1, 0, zero_miss});
    directed.push_back('{16'sd3000, 16'sd4000, 0, zero_miss});
    directed.push_back('{-16'sd5000, 16'sd2000, 0, zero_miss});
    directed.push_back('{-16'sd3000, -16'sd100, 0, zero_miss});
    directed.push_back('{16'sd768, 16'sd0, 0, zero_miss});
    directed.push_back('{16'sd9473, 16'sd0, 0, zero_miss});
    foreach (directed[i]) begin
      send_target(directed[i].x, directed[i].y);
      if (directed[i].known) begin
        pose_tmp = expected_poses[$];
        check_pose($sformatf("directed row %0d", i), pose_tmp, directed[i].pose);
      end
    end
    random_targets(250);

    // A zero-length link hits the zero-denominator arc cosine.
    write_link(ikc_pkg::CFG_LOWER, 14'd0);
    send_target(16'sd5120, 16'sd0);
    send_target(16'sd0, 16'sd2000);
    random_targets(150);
    write_link(ikc_pkg::CFG_UPPER, 14'd0);
    send_target(16'sd100, 16'sd100);
    random_targets(50);
    // An out-of-range index is ignored.
    write_link(2'd3, 14'd777);
    write_link(ikc_pkg::CFG_UPPER, 14'd16383);
    write_link(ikc_pkg::CFG_LOWER, 14'd16383);
    send_target(-16'sd32768, -16'sd32768);
    send_target(16'sd32767, -16'sd32768);
    random_targets(300);
    write_link(ikc_pkg::CFG_UPPER, 14'd1);
    write_link(ikc_pkg::CFG_LOWER, 14'd1);
    send_target(16'sd2, 16'sd0);
    send_target(16'sd1, 16'sd1);
    random_targets(100);
    write_link(ikc_pkg::CFG_UPPER, 14'($urandom_range(100, 9000)));
    write_link(ikc_pkg::CFG_LOWER, 14'($urandom_range(100, 9000)));
    random_targets(500);
    write_link(ikc_pkg::CFG_UPPER, ikc_pkg::UPPER_RESET);
    write_link(ikc_pkg::CFG_LOWER, ikc_pkg::LOWER_RESET);
    random_targets(200);
    calm = 1;
    random_targets(200);
    push <= 0;

    while (expected_poses.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
